### rtl/flight_termination_monitor_defines.svh
// Assertion macros for the flight termination monitor.
`ifndef FLIGHT_TERMINATION_MONITOR_DEFINES_SVH
`define FLIGHT_TERMINATION_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define FTM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftm assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define FTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftm assertion failed");

`endif

### rtl/ftm_pkg.sv
`timescale 1ns / 1ps
package ftm_pkg;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int CNT_W   = 16;

  localparam int unsigned ARM_TICKS_DEF  = 100;
  localparam int unsigned TILT_LIMIT_DEF = 4500;
  localparam int          LEVEL_ANGLE    = 9000;

  localparam logic [4:0] MODE_NORMAL = 5'd0;
  localparam logic [4:0] MODE_MANUAL = 5'd3;
  localparam logic [4:0] MODE_TERM   = 5'd31;

  localparam logic [2:0] REG_DESCENT_LIMIT = 3'd0;
  localparam logic [2:0] REG_YAW_LIMIT     = 3'd1;
  localparam logic [2:0] REG_BOX_HALF_LAT  = 3'd2;
  localparam logic [2:0] REG_BOX_HALF_LON  = 3'd3;
  localparam logic [2:0] REG_GROUND_MARGIN = 3'd4;
  localparam logic [2:0] REG_GOAL_LAT      = 3'd5;
  localparam logic [2:0] REG_GOAL_LON      = 3'd6;
  localparam logic [2:0] REG_GOAL_ALT      = 3'd7;

  typedef struct packed {
    logic [14:0] descent_rate_limit;
    logic [14:0] yaw_rate_limit;
    logic [26:0] box_half_lat;
    logic [26:0] box_half_lon;
    logic [16:0] ground_margin;
    logic [30:0] goal_lat;
    logic [31:0] goal_lon;
    logic [19:0] goal_alt;
  } ftm_cfg_t;

  typedef struct packed {
    logic        baro_active;
    logic [15:0] alt_rate;
    logic [15:0] yaw_rate;
    logic [16:0] pitch;
    logic [16:0] roll;
    logic [30:0] gps_lat;
    logic [31:0] gps_lon;
    logic        gps_fix;
    logic [19:0] gps_alt;
    logic [5:0]  mode_cmd;
    logic        manual_servo;
    logic        manual_motor;
  } ftm_snap_t;

  typedef struct packed {
    logic [4:0] term_code;
    logic [4:0] mode;
    logic       servo_on;
    logic       motor_enabled;
    logic       arms_open;
    logic       motors_running;
    logic       terminated_now;
  } ftm_rpt_t;

endpackage

### rtl/ftm_regs.sv
`timescale 1ns / 1ps
module ftm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftm_pkg::PADDR_W-1:0]   paddr,
  input  logic [ftm_pkg::PDATA_W-1:0]   pwdata,
  output logic [ftm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output ftm_pkg::ftm_cfg_t             cfg
);
  import ftm_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.descent_rate_limit <= 15'd1000;
      cfg.yaw_rate_limit     <= 15'd3600;
      cfg.box_half_lat       <= 27'd5000;
      cfg.box_half_lon       <= 27'd5000;
      cfg.ground_margin      <= 17'd50;
      cfg.goal_lat           <= '0;
      cfg.goal_lon           <= '0;
      cfg.goal_alt           <= '0;
    end else if (wr) begin
      case (idx)
        REG_DESCENT_LIMIT: cfg.descent_rate_limit <= pwdata[14:0];
        REG_YAW_LIMIT:     cfg.yaw_rate_limit     <= pwdata[14:0];
        REG_BOX_HALF_LAT:  cfg.box_half_lat       <= pwdata[26:0];
        REG_BOX_HALF_LON:  cfg.box_half_lon       <= pwdata[26:0];
        REG_GROUND_MARGIN: cfg.ground_margin      <= pwdata[16:0];
        REG_GOAL_LAT:      cfg.goal_lat           <= pwdata[30:0];
        REG_GOAL_LON:      cfg.goal_lon           <= pwdata[31:0];
        REG_GOAL_ALT:      cfg.goal_alt           <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DESCENT_LIMIT: prdata = {17'd0, cfg.descent_rate_limit};
      REG_YAW_LIMIT:     prdata = {17'd0, cfg.yaw_rate_limit};
      REG_BOX_HALF_LAT:  prdata = {5'd0, cfg.box_half_lat};
      REG_BOX_HALF_LON:  prdata = {5'd0, cfg.box_half_lon};
      REG_GROUND_MARGIN: prdata = {15'd0, cfg.ground_margin};
      REG_GOAL_LAT:      prdata = {1'b0, cfg.goal_lat};
      REG_GOAL_LON:      prdata = cfg.goal_lon;
      REG_GOAL_ALT:      prdata = {12'd0, cfg.goal_alt};
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/ftm_cond.sv
`timescale 1ns / 1ps
module ftm_cond #(
  parameter int unsigned TILT_LIMIT = ftm_pkg::TILT_LIMIT_DEF
) (
  input  ftm_pkg::ftm_snap_t snap,
  input  ftm_pkg::ftm_cfg_t  cfg,
  output logic [4:0]         code
);
  import ftm_pkg::*;

  localparam logic [17:0] TILT_VAL  = 18'(TILT_LIMIT);
  localparam logic [17:0] LEVEL_VAL = 18'(LEVEL_ANGLE);

  logic [15:0]        alt_mag;
  logic [15:0]        yaw_mag;
  logic [17:0]        pitch_d;
  logic [17:0]        roll_d;
  logic [17:0]        pitch_mag;
  logic [17:0]        roll_mag;
  logic [31:0]        lat_d;
  logic [31:0]        lat_mag;
  logic [32:0]        lon_d;
  logic [32:0]        lon_mag;
  logic signed [20:0] alt_d;
  logic signed [20:0] margin_s;

  always_comb begin
    alt_mag   = snap.alt_rate[15] ? 16'(-snap.alt_rate) : snap.alt_rate;
    yaw_mag   = snap.yaw_rate[15] ? 16'(-snap.yaw_rate) : snap.yaw_rate;
    pitch_d   = {snap.pitch[16], snap.pitch} - LEVEL_VAL;
    roll_d    = {snap.roll[16], snap.roll} - LEVEL_VAL;
    pitch_mag = pitch_d[17] ? 18'(-pitch_d) : pitch_d;
    roll_mag  = roll_d[17] ? 18'(-roll_d) : roll_d;
    lat_d     = {snap.gps_lat[30], snap.gps_lat} - {cfg.goal_lat[30], cfg.goal_lat};
    lat_mag   = lat_d[31] ? 32'(-lat_d) : lat_d;
    lon_d     = {snap.gps_lon[31], snap.gps_lon} - {cfg.goal_lon[31], cfg.goal_lon};
    lon_mag   = lon_d[32] ? 33'(-lon_d) : lon_d;
    alt_d     = $signed({snap.gps_alt[19], snap.gps_alt})
              - $signed({cfg.goal_alt[19], cfg.goal_alt});
    margin_s  = $signed({4'd0, cfg.ground_margin});

    code[0] = snap.baro_active && (alt_mag > {1'b0, cfg.descent_rate_limit});
    code[1] = yaw_mag > {1'b0, cfg.yaw_rate_limit};
    code[2] = (pitch_mag > TILT_VAL) || (roll_mag > TILT_VAL);
    code[3] = (lat_mag < {5'd0, cfg.box_half_lat}) && (lon_mag < {6'd0, cfg.box_half_lon});
    code[4] = snap.gps_fix && (alt_d < margin_s);
  end

endmodule

### rtl/ftm_ctrl.sv
`timescale 1ns / 1ps
module ftm_ctrl #(
  parameter int unsigned ARM_TICKS = ftm_pkg::ARM_TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  ftm_pkg::ftm_snap_t snap,
  input  logic [4:0]         code,
  output ftm_pkg::ftm_rpt_t  rpt
);
  import ftm_pkg::*;

  localparam logic [CNT_W-1:0] ARM_VAL = CNT_W'(ARM_TICKS);

  logic [4:0]       mode_reg,   mode_reg_next;
  logic [CNT_W-1:0] arming_count, arming_count_next;
  logic             servo_flag, servo_flag_next;
  logic             motor_flag, motor_flag_next;
  logic             arms_state, arms_state_next;
  logic             driver_on,  driver_on_next;
  logic             entered;
  logic [4:0]       m0;
  logic             shut;

  always_comb begin
    m0                = snap.mode_cmd[5] ? mode_reg : snap.mode_cmd[4:0];
    mode_reg_next     = m0;
    arming_count_next = arming_count;
    servo_flag_next   = (m0 == MODE_MANUAL) ? snap.manual_servo : servo_flag;
    motor_flag_next   = (m0 == MODE_MANUAL) ? snap.manual_motor : motor_flag;
    arms_state_next   = arms_state;
    driver_on_next    = driver_on;
    entered           = 1'b0;
    shut              = 1'b0;

    if (m0 == MODE_TERM) begin
      if (code == 5'd0) begin
        mode_reg_next = MODE_NORMAL;
      end else begin
        shut = 1'b1;
      end
    end else if (m0 != MODE_MANUAL && code != 5'd0) begin
      mode_reg_next     = MODE_TERM;
      arming_count_next = '0;
      entered           = 1'b1;
      shut              = 1'b1;
    end else begin
      if (m0 == MODE_MANUAL) begin
        arming_count_next = ARM_VAL;
      end
      if (m0 == MODE_MANUAL || arming_count >= ARM_VAL) begin
        if (m0 != MODE_MANUAL) begin
          servo_flag_next = 1'b1;
          motor_flag_next = 1'b1;
        end
        if (servo_flag_next) begin
          arms_state_next = 1'b1;
        end
        if (motor_flag_next) begin
          driver_on_next = 1'b1;
        end
      end else begin
        arming_count_next = arming_count + 1'b1;
      end
    end

    if (shut) begin
      servo_flag_next = 1'b0;
      motor_flag_next = 1'b0;
      arms_state_next = 1'b0;
      driver_on_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_NORMAL;
      arming_count <= '0;
      servo_flag   <= 1'b0;
      motor_flag   <= 1'b0;
      arms_state   <= 1'b0;
      driver_on    <= 1'b0;
    end else if (adv) begin
      mode_reg     <= mode_reg_next;
      arming_count <= arming_count_next;
      servo_flag   <= servo_flag_next;
      motor_flag   <= motor_flag_next;
      arms_state   <= arms_state_next;
      driver_on    <= driver_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rpt.term_code      <= code;
      rpt.mode           <= mode_reg_next;
      rpt.servo_on       <= servo_flag_next;
      rpt.motor_enabled  <= motor_flag_next;
      rpt.arms_open      <= arms_state_next;
      rpt.motors_running <= driver_on_next;
      rpt.terminated_now <= entered;
    end
  end

endmodule

### rtl/flight_termination_monitor.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload     Word
// snap      snap_valid / snap_ready    snap        one sensor snapshot per tick
// rpt       rpt_valid / rpt_ready      rpt         one status report per snapshot
// cfg       psel / penable / pwrite    paddr/pwdata  APB register write, pready tied high
//
// One snapshot per cycle unless the report stalls; stage one feeds the report register.
// Stage one holds the snapshot, the condition code and state update sit between it
// and the report register.
// Synchronous active-high reset clears mode, counter, flags and both valid bits;
// registers return to their defaults.
// A stalled report holds the pipe; an empty input stage may still fill meanwhile.
module flight_termination_monitor #(
  parameter int unsigned ARM_TICKS  = ftm_pkg::ARM_TICKS_DEF,
  parameter int unsigned TILT_LIMIT = ftm_pkg::TILT_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          snap_valid,
  output logic                          snap_ready,
  input  ftm_pkg::ftm_snap_t            snap,
  output logic                          rpt_valid,
  input  logic                          rpt_ready,
  output ftm_pkg::ftm_rpt_t             rpt,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftm_pkg::PADDR_W-1:0]   paddr,
  input  logic [ftm_pkg::PDATA_W-1:0]   pwdata,
  output logic [ftm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ftm_pkg::*;

  ftm_cfg_t   cfg;
  ftm_snap_t  s1;
  logic       s1_valid;
  logic       rpt_move;
  logic       adv;
  logic [4:0] code;

  assign rpt_move   = !rpt_valid || rpt_ready;
  assign adv        = s1_valid && rpt_move;
  assign snap_ready = !s1_valid || rpt_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rpt_valid <= 1'b0;
    end else begin
      if (snap_ready) begin
        s1_valid <= snap_valid;
      end
      if (rpt_move) begin
        rpt_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      s1 <= snap;
    end
  end

  ftm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ftm_cond #(
    .TILT_LIMIT (TILT_LIMIT)
  ) u_cond (
    .snap (s1),
    .cfg  (cfg),
    .code (code)
  );

  ftm_ctrl #(
    .ARM_TICKS (ARM_TICKS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .snap (s1),
    .code (code),
    .rpt  (rpt)
  );

endmodule

### rtl/ftm_checker.sv
`timescale 1ns / 1ps
`include "flight_termination_monitor_defines.svh"
module ftm_checker (
  input logic              clk,
  input logic              rst,
  input logic              rpt_valid,
  input logic              rpt_ready,
  input ftm_pkg::ftm_rpt_t rpt
);
  import ftm_pkg::*;

  logic all_off;
  logic term_mode;
  logic free_mode;
  logic calm;

  assign all_off   = !rpt.servo_on && !rpt.motor_enabled && !rpt.arms_open
                   && !rpt.motors_running;
  assign term_mode = rpt.mode == MODE_TERM;
  assign free_mode = rpt.mode != MODE_TERM && rpt.mode != MODE_MANUAL;
  assign calm      = rpt.term_code == 5'd0 && !rpt.terminated_now;

  `FTM_ASSERT_NEXT(a_rpt_hold, clk, rst, rpt_valid && !rpt_ready, rpt_valid && $stable(rpt))
  `FTM_ASSERT_NOW(a_entry_shut, clk, rst, rpt_valid && rpt.terminated_now, term_mode && all_off)
  `FTM_ASSERT_NOW(a_term_shut, clk, rst, rpt_valid && term_mode && rpt.term_code != 5'd0, all_off)
  `FTM_ASSERT_NOW(a_code_forces_term, clk, rst, rpt_valid && free_mode, calm)

endmodule

bind flight_termination_monitor ftm_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .rpt_valid (rpt_valid),
  .rpt_ready (rpt_ready),
  .rpt       (rpt)
);
